// ----- hw/rtl/prpa_pkg.sv -----
// Shared constants, command codes and helper functions of the port range allocator.
`timescale 1ns / 1ps

package prpa_pkg;

   localparam int MAX_PORTS = 1024;
   localparam int PORT_W    = 16;
   localparam int CMD_W     = 2;
   localparam int WORD_W    = 32;
   localparam int BIT_W     = $clog2(WORD_W);
   localparam int IDX_W     = $clog2(MAX_PORTS);
   localparam int NUM_WORDS = MAX_PORTS / WORD_W;
   localparam int WADDR_W   = IDX_W - BIT_W;
   localparam int CAP_W     = PORT_W + 1;
   localparam int CSR_IDX_W = 2;

   localparam logic [CMD_W-1:0] CMD_ACQUIRE      = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ACQUIRE_PAIR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE      = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RELEASE_PAIR = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_END   = 2'd1;

   localparam logic [PORT_W-1:0] RANGE_START_RST = 16'd1;
   localparam logic [PORT_W-1:0] RANGE_END_RST   = 16'd1024;

   // Lowest set bit of a bitmap word: {hit, position}.
   function automatic logic [BIT_W:0] lowest_one(input logic [WORD_W-1:0] v);
      logic [BIT_W-1:0] pos;
      logic             hit;
      pos = '0;
      hit = 1'b0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            pos = BIT_W'(i);
            hit = 1'b1;
         end
      end
      return {hit, pos};
   endfunction

endpackage

// ----- hw/rtl/port_range_pair_allocator.sv -----
// Top level of the port range allocator: bitmap memory, scan sequencer and release logic.
`timescale 1ns / 1ps

// The port range allocator hands out port numbers from [range_start, range_end],
// tracking reservations in a 1024-bit bitmap held as 32 words of 32 bits in a
// synchronous memory. A request is accepted when start is high and busy is low;
// req_cmd selects acquire, acquire pair, release one or release pair.
// Each request yields exactly one response, shown for one cycle with rsp_valid
// high; the receiver cannot stall it, and the next request may be accepted in
// that same cycle. An acquire scans the bitmap one word at a time, and each
// word takes a read state and then a check state on the single memory port;
// the scan covers the words that hold the range, at most 32. On an empty range
// the response is registered straight from the idle state. An odd-aligned pair
// that straddles two words needs the extra state S_WR_PREV for the second write.
// A release passes through a read state and a write state for each port that
// lies in range, and skips a port that does not.
// Reset clears the range registers to 1 and 1024 and marks every bitmap word
// as unwritten through per-word valid flags, so all ports are free at once
// and no clearing pass is needed. The range registers are written through
// the csr_ port and must only change while the block is idle.
module port_range_pair_allocator
   import prpa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [PORT_W-1:0]    req_port,
   input  logic [PORT_W-1:0]    req_second_port,
   output logic                 rsp_valid,
   output logic                 rsp_found,
   output logic [PORT_W-1:0]    rsp_first_port,
   output logic [PORT_W-1:0]    rsp_pair_port,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PORT_W-1:0]    csr_wdata
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SCAN_RD  = 3'd1;
   localparam logic [2:0] S_SCAN_CHK = 3'd2;
   localparam logic [2:0] S_WR_PREV  = 3'd3;
   localparam logic [2:0] S_REL_RD   = 3'd4;
   localparam logic [2:0] S_REL_WR   = 3'd5;

   // Configuration registers.
   logic [PORT_W-1:0] range_start_ff;
   logic [PORT_W-1:0] range_end_ff;

   // Bitmap memory; a word never written reads as all free.
   logic [WORD_W-1:0]  bitmap_mem [NUM_WORDS];
   logic [NUM_WORDS-1:0] row_valid_ff;
   logic [WORD_W-1:0]  mem_rdata_ff;
   logic               rd_valid_ff;
   logic               mem_re;
   logic [WADDR_W-1:0] mem_raddr;
   logic               mem_we;
   logic [WADDR_W-1:0] mem_waddr;
   logic [WORD_W-1:0]  mem_wdata;
   logic [WORD_W-1:0]  word_data;

   // Sequencer state.
   logic [2:0]         state_ff, state_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [WADDR_W-1:0] word_ff, word_in;
   logic [WADDR_W-1:0] last_word_ff, last_word_in;
   logic [BIT_W-1:0]   last_bit_ff, last_bit_in;
   logic [WORD_W-1:0]  prev_word_ff, prev_word_in;
   logic [IDX_W-1:0]   rel_idx_ff [2];
   logic [IDX_W-1:0]   rel_idx_in [2];
   logic [1:0]         rel_ok_ff, rel_ok_in;
   logic               rel_sel_ff, rel_sel_in;

   // Response registers.
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [PORT_W-1:0] rsp_first_port_ff, rsp_first_port_in;
   logic [PORT_W-1:0] rsp_pair_port_ff, rsp_pair_port_in;

   // Range arithmetic, evaluated while idle.
   logic [CAP_W-1:0]  cap_port;
   logic [CAP_W-1:0]  top_port;
   logic              range_empty;
   logic [CAP_W-1:0]  limit_full;
   logic [IDX_W-1:0]  limit_idx;
   logic              port_ok;
   logic              second_ok;

   // Word check signals.
   logic [WORD_W-1:0] tail_mask;
   logic [WORD_W-1:0] avail;
   logic [WORD_W-1:0] pair_vec;
   logic [BIT_W:0]    single_hit;
   logic [BIT_W:0]    pair_hit;
   logic              cross_hit;
   logic [IDX_W-1:0]  hit_idx;
   logic [IDX_W-1:0]  cross_idx;
   logic [IDX_W-1:0]  rel_cur_idx;

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_first_port = rsp_first_port_ff;
   assign rsp_pair_port  = rsp_pair_port_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_start_ff <= RANGE_START_RST;
         range_end_ff   <= RANGE_END_RST;
      end else if (csr_we) begin
         if (csr_index == CSR_RANGE_START) begin
            range_start_ff <= csr_wdata;
         end
         if (csr_index == CSR_RANGE_END) begin
            range_end_ff <= csr_wdata;
         end
      end
   end

   // The memory itself: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= bitmap_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (mem_we) begin
            row_valid_ff[mem_waddr] <= 1'b1;
         end
         if (mem_re) begin
            rd_valid_ff <= row_valid_ff[mem_raddr];
         end
      end
   end

   assign word_data = rd_valid_ff ? mem_rdata_ff : '0;

   // The usable top is range_end, capped by the bitmap size above range_start.
   always_comb begin
      cap_port    = {1'b0, range_start_ff} + CAP_W'(MAX_PORTS - 1);
      top_port    = ({1'b0, range_end_ff} < cap_port) ? {1'b0, range_end_ff} : cap_port;
      range_empty = (range_end_ff < range_start_ff);
      limit_full  = top_port - {1'b0, range_start_ff};
      limit_idx   = limit_full[IDX_W-1:0];
      port_ok     = (req_port >= range_start_ff) && ({1'b0, req_port} <= top_port);
      second_ok   = (req_second_port >= range_start_ff)
                    && ({1'b0, req_second_port} <= top_port);
   end

   // Free bits of the current word, with bits past the range end masked off.
   always_comb begin
      for (int i = 0; i < WORD_W; i++) begin
         tail_mask[i] = (BIT_W'(i) > last_bit_ff);
      end
      avail = ~word_data & ~((word_ff == last_word_ff) ? tail_mask : '0);
      pair_vec = '0;
      for (int i = 0; i < WORD_W - 1; i++) begin
         pair_vec[i] = avail[i] & avail[i + 1] & ((i % 2 == 1) == range_start_ff[0]);
      end
      single_hit = lowest_one(avail);
      pair_hit   = lowest_one(pair_vec);
      // With an odd start, the pair made of the previous word's top bit and
      // this word's bottom bit comes before every pair inside this word.
      cross_hit  = range_start_ff[0] && (word_ff != '0) && !prev_word_ff[WORD_W-1]
                   && avail[0];
      hit_idx    = {word_ff, (cmd_ff == CMD_ACQUIRE) ? single_hit[BIT_W-1:0]
                                                     : pair_hit[BIT_W-1:0]};
      cross_idx  = {word_ff, BIT_W'(0)} - IDX_W'(1);
      rel_cur_idx = rel_idx_ff[rel_sel_ff];
   end

   always_comb begin
      state_in          = state_ff;
      cmd_in            = cmd_ff;
      word_in           = word_ff;
      last_word_in      = last_word_ff;
      last_bit_in       = last_bit_ff;
      prev_word_in      = prev_word_ff;
      rel_idx_in        = rel_idx_ff;
      rel_ok_in         = rel_ok_ff;
      rel_sel_in        = rel_sel_ff;
      rsp_valid_in      = 1'b0;
      rsp_found_in      = rsp_found_ff;
      rsp_first_port_in = rsp_first_port_ff;
      rsp_pair_port_in  = rsp_pair_port_ff;
      mem_re            = 1'b0;
      mem_raddr         = word_ff;
      mem_we            = 1'b0;
      mem_waddr         = word_ff;
      mem_wdata         = word_data;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in            = req_cmd;
               word_in           = '0;
               last_word_in      = limit_idx[IDX_W-1:BIT_W];
               last_bit_in       = limit_idx[BIT_W-1:0];
               rel_idx_in[0]     = IDX_W'(req_port - range_start_ff);
               rel_idx_in[1]     = IDX_W'(req_second_port - range_start_ff);
               rel_ok_in         = {second_ok && (req_cmd == CMD_RELEASE_PAIR), port_ok};
               rel_sel_in        = 1'b0;
               rsp_found_in      = 1'b0;
               rsp_first_port_in = '0;
               rsp_pair_port_in  = '0;
               if (req_cmd == CMD_RELEASE || req_cmd == CMD_RELEASE_PAIR) begin
                  state_in = S_REL_RD;
               end else if (range_empty) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_SCAN_RD: begin
            mem_re   = 1'b1;
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            prev_word_in = word_data;
            if (cmd_ff == CMD_ACQUIRE && single_hit[BIT_W]) begin
               mem_we            = 1'b1;
               mem_wdata         = word_data | (WORD_W'(1) << single_hit[BIT_W-1:0]);
               rsp_found_in      = 1'b1;
               rsp_first_port_in = range_start_ff + PORT_W'(hit_idx);
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end else if (cmd_ff == CMD_ACQUIRE_PAIR && cross_hit) begin
               // Bottom bit here now; the previous word's top bit next cycle,
               // so the previous word's contents are kept for that write.
               prev_word_in      = prev_word_ff;
               mem_we            = 1'b1;
               mem_wdata         = word_data | WORD_W'(1);
               rsp_found_in      = 1'b1;
               rsp_first_port_in = range_start_ff + PORT_W'(cross_idx);
               rsp_pair_port_in  = range_start_ff + PORT_W'(cross_idx) + PORT_W'(1);
               state_in          = S_WR_PREV;
            end else if (cmd_ff == CMD_ACQUIRE_PAIR && pair_hit[BIT_W]) begin
               mem_we            = 1'b1;
               mem_wdata         = word_data | (WORD_W'(3) << pair_hit[BIT_W-1:0]);
               rsp_found_in      = 1'b1;
               rsp_first_port_in = range_start_ff + PORT_W'(hit_idx);
               rsp_pair_port_in  = range_start_ff + PORT_W'(hit_idx) + PORT_W'(1);
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end else if (word_ff == last_word_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               word_in  = word_ff + WADDR_W'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_WR_PREV: begin
            mem_we       = 1'b1;
            mem_waddr    = word_ff - WADDR_W'(1);
            mem_wdata    = prev_word_ff | (WORD_W'(1) << (WORD_W - 1));
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_REL_RD: begin
            if (rel_ok_ff[rel_sel_ff]) begin
               mem_re    = 1'b1;
               mem_raddr = rel_cur_idx[IDX_W-1:BIT_W];
               state_in  = S_REL_WR;
            end else if (rel_sel_ff) begin
               rsp_found_in = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               rel_sel_in = 1'b1;
            end
         end
         S_REL_WR: begin
            mem_we    = 1'b1;
            mem_waddr = rel_cur_idx[IDX_W-1:BIT_W];
            mem_wdata = word_data & ~(WORD_W'(1) << rel_cur_idx[BIT_W-1:0]);
            if (rel_sel_ff) begin
               rsp_found_in = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               rel_sel_in = 1'b1;
               state_in   = S_REL_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff            <= cmd_in;
      word_ff           <= word_in;
      last_word_ff      <= last_word_in;
      last_bit_ff       <= last_bit_in;
      prev_word_ff      <= prev_word_in;
      rel_idx_ff        <= rel_idx_in;
      rel_ok_ff         <= rel_ok_in;
      rel_sel_ff        <= rel_sel_in;
      rsp_found_ff      <= rsp_found_in;
      rsp_first_port_ff <= rsp_first_port_in;
      rsp_pair_port_ff  <= rsp_pair_port_in;
   end

   // The single memory port never reads and writes in the same cycle.
   a_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("bitmap memory read and written in the same cycle");

   // The scan never runs past the word that holds the end of the range.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN_CHK) |-> (word_ff <= last_word_ff))
      else $error("bitmap scan passed the last word of the range");

   // A failed allocation reports no ports.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_first_port == '0 && rsp_pair_port == '0))
      else $error("failed allocation carries a port number");

   // A pair result is an even port followed by its odd neighbor.
   a_pair_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pair_port != '0)
         |-> (rsp_pair_port == rsp_first_port + PORT_W'(1) && !rsp_first_port[0]))
      else $error("pair result is not an even-aligned pair");

   // A response follows work in progress on the previous cycle or an idle accept.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start)))
      else $error("response without a request");

endmodule
